// ----- rtl/bfz_pkg.sv -----
// Package for the 3x3 zero-padded box filter.
// Field widths, register indexes, input op codes, result word type and divide constants.
// No dependencies.
package bfz_pkg;

    localparam int PIX_W     = 16;
    localparam int MEAN_W    = 20;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 20;
    localparam int CSUM_W    = 18;
    localparam int ROW_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [CFG_W-1:0] HEIGHT_MAX = 13'd4096;

    // result queue
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = 3;
    localparam int RQ_CW    = 4;

    // x / 9 == (x * RECIP) >> RECIP_SH, exact for x < 2^24
    localparam int          DIVIN_W  = 24;
    localparam int          RECIP_W  = 25;
    localparam logic [24:0] RECIP    = 25'd29826162;
    localparam int          RECIP_SH = 28;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_value;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_done;
        logic               last_in_run;
    } t_result;

    typedef struct packed {
        logic va;
        logic vb;
    } t_push;

endpackage

// ----- rtl/bfz_in_if.sv -----
// Input pixel channel of the box filter.
// Depends on bfz_pkg.
interface bfz_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [bfz_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

// ----- rtl/bfz_out_if.sv -----
// Result channel of the box filter.
// Depends on bfz_pkg.
interface bfz_out_if;
    logic                        valid;
    logic                        ready;
    logic [bfz_pkg::MEAN_W-1:0]  mean_value;
    logic [bfz_pkg::COORD_W-1:0] out_row;
    logic [bfz_pkg::COORD_W-1:0] out_col;
    logic                        frame_done;
    logic                        last_in_run;

    modport source (output valid, output mean_value, output out_row, output out_col,
                    output frame_done, output last_in_run, input ready);
    modport sink   (input valid, input mean_value, input out_row, input out_col,
                    input frame_done, input last_in_run, output ready);
endinterface

// ----- rtl/bfz_line_buf.sv -----
// Two line stores (rows R-2 and R-1) with registered read and write-to-read bypass.
// Standalone; no package use.
module bfz_line_buf #(
    parameter int MAX_WIDTH = 4096,
    parameter int DATA_W    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]            i_wr_up,
    input  logic [DATA_W-1:0]            i_wr_lo,
    output logic [DATA_W-1:0]            o_rd_up,
    output logic [DATA_W-1:0]            o_rd_lo
);

    logic [DATA_W-1:0] r_mem_up [MAX_WIDTH];
    logic [DATA_W-1:0] r_mem_lo [MAX_WIDTH];
    logic [DATA_W-1:0] r_rd_up;
    logic [DATA_W-1:0] r_rd_lo;
    logic              hit;

    assign hit = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_up[i_wr_addr] <= i_wr_up;
            r_mem_lo[i_wr_addr] <= i_wr_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_up <= hit ? i_wr_up : r_mem_up[i_rd_addr];
            r_rd_lo <= hit ? i_wr_lo : r_mem_lo[i_rd_addr];
        end
    end

    assign o_rd_up = r_rd_up;
    assign o_rd_lo = r_rd_lo;

endmodule

// ----- rtl/bfz_res_fifo.sv -----
// Result queue: takes up to two result words a cycle, gives one a cycle while the sink is ready.
// Depends on bfz_pkg and bfz_out_if. Space is reserved upstream.
module bfz_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfz_pkg::t_push   i_push,
    input  bfz_pkg::t_result i_res_a,
    input  bfz_pkg::t_result i_res_b,
    bfz_out_if.source        o_res_ch
);

    bfz_pkg::t_result                r_mem [bfz_pkg::RQ_DEPTH];
    logic [bfz_pkg::RQ_AW-1:0]       r_wp;
    logic [bfz_pkg::RQ_AW-1:0]       r_rp;
    logic [bfz_pkg::RQ_CW-1:0]       r_cnt;
    logic [bfz_pkg::RQ_AW-1:0]       wp_b;
    logic                            pop;
    logic [bfz_pkg::RQ_CW-1:0]       n_push;
    bfz_pkg::t_result                head;

    assign pop    = o_res_ch.valid && o_res_ch.ready;
    assign wp_b   = r_wp + bfz_pkg::RQ_AW'(i_push.va);
    assign n_push = bfz_pkg::RQ_CW'(i_push.va) + bfz_pkg::RQ_CW'(i_push.vb);

    always_ff @(posedge i_clk) begin
        if (i_push.va) begin
            r_mem[r_wp] <= i_res_a;
        end
        if (i_push.vb) begin
            r_mem[wp_b] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + bfz_pkg::RQ_AW'(n_push);
            r_rp  <= r_rp + bfz_pkg::RQ_AW'(pop);
            r_cnt <= r_cnt + n_push - bfz_pkg::RQ_CW'(pop);
        end
    end

    assign head                 = r_mem[r_rp];
    assign o_res_ch.valid       = (r_cnt != '0);
    assign o_res_ch.mean_value  = head.mean_value;
    assign o_res_ch.out_row     = head.out_row;
    assign o_res_ch.out_col     = head.out_col;
    assign o_res_ch.frame_done  = head.frame_done;
    assign o_res_ch.last_in_run = head.last_in_run;

endmodule

// ----- rtl/box_filter_3x3_zero_pad_top.sv -----
// Top level of the streaming 3x3 box filter with zero padding, Q16.4 mean output.
// Depends on bfz_pkg, bfz_in_if, bfz_out_if, bfz_line_buf, bfz_res_fifo.
//
//  channel     dir  handshake      payload
//  i_pix_ch    in   valid/ready    op, pixel
//  o_res_ch    out  valid/ready    mean_value, out_row, out_col, frame_done, last_in_run
//  i_cfg_*     in   write enable   index, 13-bit data
//
// One input word per cycle while ready is high; each accepted word passes stage A (line
// store read) and stage B (window sums), then the divide by nine feeds the result queue
// directly, from whose head result words are valid at the output.
// Ready drops only when the 8-word result queue could not hold two more words.
// Reset restores 640x480 and position (0, 0); a width or height write restarts at (0, 0).
module box_filter_3x3_zero_pad_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfz_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfz_pkg::CFG_W-1:0]       i_cfg_data,
    bfz_in_if.sink                          i_pix_ch,
    bfz_out_if.source                       o_res_ch
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = bfz_pkg::PIX_W;

    // configuration and position
    logic [bfz_pkg::CFG_W-1:0] r_width;
    logic [bfz_pkg::CFG_W-1:0] r_height;
    logic [CW-1:0]             r_col;
    logic [bfz_pkg::ROW_W-1:0] r_row;
    logic [CW:0]               eff_w;
    logic [CW-1:0]             w_m1;
    logic [bfz_pkg::ROW_W-1:0] h_eff;
    logic                      accept;
    logic                      pop;
    logic [bfz_pkg::RQ_CW-1:0] r_pend;

    // accept-side decode
    logic                       c_drain;
    logic                       c_e1;
    logic                       c_e2;
    logic [31:0]                c_col32;
    logic [bfz_pkg::ROW_W-1:0]  c_orow;

    // stage A
    logic                        r_a_valid;
    logic [CW-1:0]               r_a_col;
    logic [PW-1:0]               r_a_pix;
    logic                        r_a_top_ok;
    logic                        r_a_bot_ok;
    logic                        r_a_ge1;
    logic                        r_a_ge2;
    logic                        r_a_e1;
    logic                        r_a_e2;
    logic                        r_a_done;
    logic [bfz_pkg::COORD_W-1:0] r_a_orow;
    logic [bfz_pkg::COORD_W-1:0] r_a_ocol;
    logic [bfz_pkg::COORD_W-1:0] r_a_ocol_m1;
    logic [PW-1:0]               lb_up;
    logic [PW-1:0]               lb_lo;

    logic [PW-1:0]               r_win [9];
    logic [PW-1:0]               n_win [9];
    logic [bfz_pkg::CSUM_W-1:0]  cs [3];
    logic [bfz_pkg::SUM_W-1:0]   sum1;
    logic [bfz_pkg::SUM_W-1:0]   sum2;

    // stage B
    logic                        r_b_e1;
    logic                        r_b_e2;
    logic [bfz_pkg::SUM_W-1:0]   r_b_s1;
    logic [bfz_pkg::SUM_W-1:0]   r_b_s2;
    logic                        r_b_done;
    logic [bfz_pkg::COORD_W-1:0] r_b_orow;
    logic [bfz_pkg::COORD_W-1:0] r_b_ocol;
    logic [bfz_pkg::COORD_W-1:0] r_b_ocol_m1;
    logic [bfz_pkg::DIVIN_W-1:0] div_in1;
    logic [bfz_pkg::DIVIN_W-1:0] div_in2;
    logic [bfz_pkg::DIVIN_W+bfz_pkg::RECIP_W-1:0] prod1;
    logic [bfz_pkg::DIVIN_W+bfz_pkg::RECIP_W-1:0] prod2;
    bfz_pkg::t_push              push;
    bfz_pkg::t_result            res_a;
    bfz_pkg::t_result            res_b;

    // effective size
    always_comb begin
        if (r_width == '0) begin
            eff_w = (CW+1)'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end else begin
            eff_w = (CW+1)'(r_width);
        end
        if (r_height == '0) begin
            h_eff = bfz_pkg::ROW_W'(1);
        end else if (r_height > bfz_pkg::HEIGHT_MAX) begin
            h_eff = bfz_pkg::HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
    end
    assign w_m1 = CW'(eff_w - (CW+1)'(1));

    assign i_pix_ch.ready = (r_pend <= bfz_pkg::RQ_CW'(bfz_pkg::RQ_DEPTH - 2));
    assign accept         = i_pix_ch.valid && i_pix_ch.ready;
    assign pop            = o_res_ch.valid && o_res_ch.ready;

    assign c_drain = (r_row >= h_eff);
    assign c_e1    = (r_row != '0) && (r_col != '0);
    assign c_e2    = (r_row != '0) && (r_col == w_m1);
    assign c_col32 = 32'(r_col);
    assign c_orow  = r_row - bfz_pkg::ROW_W'(1);

    // config, position and result reservation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bfz_pkg::WIDTH_RST;
            r_height <= bfz_pkg::HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
        end else begin
            r_pend <= r_pend
                      + (accept ? bfz_pkg::RQ_CW'(c_e1) + bfz_pkg::RQ_CW'(c_e2) : '0)
                      - bfz_pkg::RQ_CW'(pop);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfz_pkg::REG_WIDTH: begin
                        r_width <= i_cfg_data;
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    bfz_pkg::REG_HEIGHT: begin
                        r_height <= i_cfg_data;
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    default: ;
                endcase
            end else if (accept) begin
                if (r_col == w_m1) begin
                    r_col <= '0;
                    r_row <= c_drain ? '0 : r_row + bfz_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_col     <= r_col;
            r_a_pix     <= (c_drain || (i_pix_ch.op == bfz_pkg::OP_DRAIN))
                           ? '0 : i_pix_ch.pixel;
            r_a_top_ok  <= (r_row > bfz_pkg::ROW_W'(1));
            r_a_bot_ok  <= !c_drain;
            r_a_ge1     <= (r_col != '0);
            r_a_ge2     <= (r_col > CW'(1));
            r_a_e1      <= c_e1;
            r_a_e2      <= c_e2;
            r_a_done    <= c_drain;
            r_a_orow    <= c_orow[bfz_pkg::COORD_W-1:0];
            r_a_ocol    <= c_col32[bfz_pkg::COORD_W-1:0];
            r_a_ocol_m1 <= c_col32[bfz_pkg::COORD_W-1:0] - bfz_pkg::COORD_W'(1);
        end
    end

    bfz_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .DATA_W    (PW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_col),
        .i_wr_up   (lb_lo),
        .i_wr_lo   (r_a_pix),
        .o_rd_up   (lb_up),
        .o_rd_lo   (lb_lo)
    );

    // window shift, column sums and window sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = lb_up;
        n_win[5] = lb_lo;
        n_win[8] = r_a_pix;
        for (int k = 0; k < 3; k++) begin
            cs[k] = bfz_pkg::CSUM_W'(n_win[3+k])
                    + (r_a_top_ok ? bfz_pkg::CSUM_W'(n_win[k])   : '0)
                    + (r_a_bot_ok ? bfz_pkg::CSUM_W'(n_win[6+k]) : '0);
        end
        sum1 = bfz_pkg::SUM_W'(cs[1]) + bfz_pkg::SUM_W'(cs[2])
               + (r_a_ge2 ? bfz_pkg::SUM_W'(cs[0]) : '0);
        sum2 = bfz_pkg::SUM_W'(cs[2]) + (r_a_ge1 ? bfz_pkg::SUM_W'(cs[1]) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_a_valid) begin
            r_win <= n_win;
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_e1 <= 1'b0;
            r_b_e2 <= 1'b0;
        end else begin
            r_b_e1 <= r_a_valid && r_a_e1;
            r_b_e2 <= r_a_valid && r_a_e2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_s1      <= sum1;
            r_b_s2      <= sum2;
            r_b_done    <= r_a_done;
            r_b_orow    <= r_a_orow;
            r_b_ocol    <= r_a_ocol;
            r_b_ocol_m1 <= r_a_ocol_m1;
        end
    end

    // round(sum * 16 / 9) as (sum * 16 + 4) / 9 by reciprocal
    assign div_in1 = {r_b_s1, 4'b0000} + bfz_pkg::DIVIN_W'(4);
    assign div_in2 = {r_b_s2, 4'b0000} + bfz_pkg::DIVIN_W'(4);
    assign prod1   = div_in1 * bfz_pkg::RECIP;
    assign prod2   = div_in2 * bfz_pkg::RECIP;

    always_comb begin
        res_a.mean_value  = prod1[bfz_pkg::RECIP_SH +: bfz_pkg::MEAN_W];
        res_a.out_row     = r_b_orow;
        res_a.out_col     = r_b_ocol_m1;
        res_a.frame_done  = 1'b0;
        res_a.last_in_run = !r_b_e2;
        res_b.mean_value  = prod2[bfz_pkg::RECIP_SH +: bfz_pkg::MEAN_W];
        res_b.out_row     = r_b_orow;
        res_b.out_col     = r_b_ocol;
        res_b.frame_done  = r_b_done;
        res_b.last_in_run = 1'b1;
    end

    always_comb begin
        push.va = r_b_e1 || r_b_e2;
        push.vb = r_b_e1 && r_b_e2;
    end

    bfz_pkg::t_result res_first;
    assign res_first = r_b_e1 ? res_a : res_b;

    bfz_res_fifo u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res_a  (res_first),
        .i_res_b  (res_b),
        .o_res_ch (o_res_ch)
    );

endmodule

// ----- tb/tb_box_filter_3x3_zero_pad_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for box_filter_3x3_zero_pad_top: raster frames of many sizes,
// random handshake gaps on both channels, every result word checked by a local predictor.
// Depends on bfz_pkg, bfz_in_if, bfz_out_if and the filter RTL.
module tb_box_filter_3x3_zero_pad_top;

    localparam int MAX_W          = 4096;
    localparam int ITEM_TARGET    = 1150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [bfz_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bfz_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [bfz_pkg::PIX_W-1:0]  PIX_FULL       = '1;
    localparam logic [bfz_pkg::MEAN_W-1:0] MEAN_MAX       = '1;
    // four full-scale taps over nine, and one full-scale tap over nine, in Q16.4
    localparam logic [bfz_pkg::MEAN_W-1:0] MEAN_FOUR_FULL = 20'd466027;
    localparam logic [bfz_pkg::MEAN_W-1:0] MEAN_ONE_FULL  = 20'd116507;

    typedef enum logic {STEP_REG, STEP_WORD} t_step_kind;

    typedef struct {
        t_step_kind                    kind;
        logic [bfz_pkg::CFG_IDX_W-1:0] idx;
        logic [bfz_pkg::CFG_W-1:0]     data;
        logic                          op;
        logic [bfz_pkg::PIX_W-1:0]     pixel;
        bit                            typed;
        logic [bfz_pkg::MEAN_W-1:0]    mean;
    } t_step;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bfz_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bfz_pkg::CFG_W-1:0]     i_cfg_data;

    bfz_in_if  pix_ch ();
    bfz_out_if res_ch ();

    box_filter_3x3_zero_pad_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix_ch   (pix_ch),
        .o_res_ch   (res_ch)
    );

    // predictor state
    logic [bfz_pkg::CFG_W-1:0] width_reg;
    logic [bfz_pkg::CFG_W-1:0] height_reg;
    logic [bfz_pkg::PIX_W-1:0] line_two_up [MAX_W];
    logic [bfz_pkg::PIX_W-1:0] line_one_up [MAX_W];
    logic [bfz_pkg::PIX_W-1:0] win [9];
    int                        next_col;
    int                        next_row;
    bfz_pkg::t_result          fresh [2];
    bfz_pkg::t_result          expected_means [$];
    bfz_pkg::t_result          want_res;

    t_step plan [$];

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int idle_cycles     = 0;
    bit send_burst      = 1'b0;
    bit recv_burst      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_size(input logic [bfz_pkg::CFG_W-1:0] v, input int hi);
        if (v == '0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic int tap_column(input int k, input bit top_ok, input bit bot_ok);
        int s;
        s = win[3 + k];
        if (top_ok) s += win[k];
        if (bot_ok) s += win[6 + k];
        return s;
    endfunction

    function automatic bfz_pkg::t_result make_result(input int sum, input int r, input int c,
                                                     input bit done);
        bfz_pkg::t_result res;
        int               m;
        m = (sum * 16 + 4) / 9;
        if (m > int'(MEAN_MAX)) m = int'(MEAN_MAX);
        res.mean_value  = m[bfz_pkg::MEAN_W-1:0];
        res.out_row     = r[bfz_pkg::COORD_W-1:0];
        res.out_col     = c[bfz_pkg::COORD_W-1:0];
        res.frame_done  = done;
        res.last_in_run = 1'b0;
        return res;
    endfunction

    // advances the window and line stores by one word, leaves its results in fresh[]
    function automatic int predict_word(input logic op, input logic [bfz_pkg::PIX_W-1:0] pix);
        int                        w, h, col, row, sum, n, k;
        bit                        drain, top_ok, bot_ok;
        logic [bfz_pkg::PIX_W-1:0] px_in;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, int'(bfz_pkg::HEIGHT_MAX));
        if (next_col >= w) next_col = 0;
        if (next_row > h) next_row = 0;
        col   = next_col;
        row   = next_row;
        drain = (row >= h);
        px_in = (drain || op == bfz_pkg::OP_DRAIN) ? '0 : pix;

        for (k = 0; k < 3; k++) begin
            win[3*k]     = win[3*k + 1];
            win[3*k + 1] = win[3*k + 2];
        end
        win[2] = line_two_up[col];
        win[5] = line_one_up[col];
        win[8] = px_in;
        line_two_up[col] = line_one_up[col];
        line_one_up[col] = px_in;

        n = 0;
        if (row >= 1) begin
            top_ok = (row >= 2);
            bot_ok = !drain;
            if (col >= 1) begin
                sum = tap_column(1, top_ok, bot_ok) + tap_column(2, top_ok, bot_ok);
                if (col >= 2) sum += tap_column(0, top_ok, bot_ok);
                fresh[n] = make_result(sum, row - 1, col - 1,
                                       row - 1 == h - 1 && col - 1 == w - 1);
                n++;
            end
            if (col == w - 1) begin
                sum = tap_column(2, top_ok, bot_ok);
                if (col >= 1) sum += tap_column(1, top_ok, bot_ok);
                fresh[n] = make_result(sum, row - 1, col, row - 1 == h - 1);
                n++;
            end
            if (n > 0) fresh[n-1].last_in_run = 1'b1;
        end

        next_col = col + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = row + 1;
            if (next_row > h) next_row = 0;
        end
        return n;
    endfunction

    function automatic void apply_reg_write(input logic [bfz_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [bfz_pkg::CFG_W-1:0] data);
        case (idx)
            bfz_pkg::REG_WIDTH:  width_reg = data;
            bfz_pkg::REG_HEIGHT: height_reg = data;
            default:             return;
        endcase
        next_col = 0;
        next_row = 0;
    endfunction

    function automatic logic [bfz_pkg::PIX_W-1:0] any_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PIX_FULL;
            default: return bfz_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [bfz_pkg::CFG_W-1:0] pick_size(input int big_lo, input int big_hi,
                                                            input int common_hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return bfz_pkg::CFG_W'($urandom_range(big_lo, big_hi));
            default: return bfz_pkg::CFG_W'($urandom_range(1, common_hi));
        endcase
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic void add_reg(input logic [bfz_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bfz_pkg::CFG_W-1:0] data);
        t_step s;
        s = '{STEP_REG, idx, data, bfz_pkg::OP_PIXEL, '0, 1'b0, '0};
        plan.push_back(s);
    endfunction

    function automatic void add_word(input logic op, input logic [bfz_pkg::PIX_W-1:0] pix,
                                     input bit typed, input logic [bfz_pkg::MEAN_W-1:0] mean);
        t_step s;
        s = '{STEP_WORD, bfz_pkg::REG_WIDTH, '0, op, pix, typed, mean};
        plan.push_back(s);
    endfunction

    // typed rows replace the predicted mean with the hand-worked value
    task automatic send_word(input logic op, input logic [bfz_pkg::PIX_W-1:0] pix,
                             input bit typed, input logic [bfz_pkg::MEAN_W-1:0] mean);
        int gap, n, j;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.op    <= op;
        pix_ch.pixel <= pix;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        n = predict_word(op, pix);
        for (j = 0; j < n; j++) begin
            if (typed) fresh[j].mean_value = mean;
            expected_means.push_back(fresh[j]);
        end
        words_sent++;
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bfz_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfz_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input int w, input int h, input bit noisy, input int cut);
        int   k;
        logic op;
        for (k = 0; k < cut; k++) begin
            op = ((k / w) >= h) ? bfz_pkg::OP_DRAIN : bfz_pkg::OP_PIXEL;
            if (noisy && $urandom_range(0, 7) == 0) op = ~op;
            // occasional full drain mid-frame, sometimes with a write to an unused index
            if ($urandom_range(0, 299) == 0) begin
                wait_idle();
                if ($urandom_range(0, 1))
                    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                              bfz_pkg::CFG_W'($urandom));
            end
            send_word(op, any_pixel(), 1'b0, '0);
        end
    endtask

    initial begin
        int                        k, w, h, frames, full, cut;
        logic [bfz_pkg::CFG_W-1:0] wv, hv;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= bfz_pkg::REG_WIDTH;
        i_cfg_data   <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.op    <= bfz_pkg::OP_PIXEL;
        pix_ch.pixel <= '0;

        width_reg  = bfz_pkg::WIDTH_RST;
        height_reg = bfz_pkg::HEIGHT_RST;
        next_col   = 0;
        next_row   = 0;
        foreach (line_two_up[i]) begin
            line_two_up[i] = '0;
            line_one_up[i] = '0;
        end
        foreach (win[i]) win[i] = '0;

        // full-scale 2x2 frame
        add_reg(bfz_pkg::REG_WIDTH, 13'd2);
        add_reg(bfz_pkg::REG_HEIGHT, 13'd2);
        repeat (4) add_word(bfz_pkg::OP_PIXEL, PIX_FULL, 1'b1, MEAN_FOUR_FULL);
        repeat (2) add_word(bfz_pkg::OP_DRAIN, '0, 1'b1, MEAN_FOUR_FULL);
        // zero sizes clamp to 1x1
        add_reg(bfz_pkg::REG_WIDTH, '0);
        add_reg(bfz_pkg::REG_HEIGHT, '0);
        add_word(bfz_pkg::OP_PIXEL, PIX_FULL, 1'b1, MEAN_ONE_FULL);
        add_word(bfz_pkg::OP_DRAIN, PIX_FULL, 1'b1, MEAN_ONE_FULL);
        // drain op in the image, pixel op in the drain row, unused index mid-frame
        add_reg(bfz_pkg::REG_WIDTH, 13'd3);
        add_reg(bfz_pkg::REG_HEIGHT, 13'd1);
        add_word(bfz_pkg::OP_DRAIN, PIX_FULL, 1'b0, '0);
        add_word(bfz_pkg::OP_PIXEL, 16'h0000, 1'b0, '0);
        add_reg(REG_SPARE_A, 13'h1555);
        add_word(bfz_pkg::OP_PIXEL, PIX_FULL, 1'b0, '0);
        add_word(bfz_pkg::OP_PIXEL, PIX_FULL, 1'b0, '0);
        add_word(bfz_pkg::OP_DRAIN, 16'h5555, 1'b0, '0);
        add_word(bfz_pkg::OP_PIXEL, 16'hAAAA, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: one 640-word row plus three words gives two results
        for (k = 0; k < int'(bfz_pkg::WIDTH_RST) + 3; k++)
            send_word(bfz_pkg::OP_PIXEL, any_pixel(), 1'b0, '0);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_word(plan[i].op, plan[i].pixel, plan[i].typed, plan[i].mean);
            end
        end

        while (words_sent < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          bfz_pkg::CFG_W'($urandom));
            wv = pick_size(9, 20, 8);
            hv = pick_size(6, 10, 4);
            if ($urandom_range(0, 1)) begin
                write_reg(bfz_pkg::REG_WIDTH, wv);
                write_reg(bfz_pkg::REG_HEIGHT, hv);
            end else begin
                write_reg(bfz_pkg::REG_HEIGHT, hv);
                write_reg(bfz_pkg::REG_WIDTH, wv);
            end
            w      = clamp_size(width_reg, MAX_W);
            h      = clamp_size(height_reg, int'(bfz_pkg::HEIGHT_MAX));
            full   = (h + 1) * w;
            frames = $urandom_range(1, 3);
            for (k = 0; k < frames; k++) begin
                if (words_sent >= ITEM_TARGET) break;
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, full) : full;
                if (cut > ITEM_TARGET - words_sent) cut = ITEM_TARGET - words_sent;
                send_frame(w, h, $urandom_range(0, 4) == 0, cut);
                if (cut < full) break;
            end
        end

        wait_idle();
        $display("Sent %0d pixel words, checked %0d result words.", words_sent,
                 results_checked);
        $display("Reset 640-wide size, full-scale and zero-size frames, random sizes up to 20x10,");
        $display("noisy ops, frames cut short and writes to unused indexes.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_means.size() == 0) begin
                errors++;
                $display("%0t: expected no word, got mean %0d row %0d col %0d",
                         $time, res_ch.mean_value, res_ch.out_row, res_ch.out_col);
            end else begin
                want_res = expected_means.pop_front();
                check_field("mean_value", want_res.mean_value, res_ch.mean_value);
                check_field("out_row", want_res.out_row, res_ch.out_row);
                check_field("out_col", want_res.out_col, res_ch.out_col);
                check_field("frame_done", want_res.frame_done, res_ch.frame_done);
                check_field("last_in_run", want_res.last_in_run, res_ch.last_in_run);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                     idle_cycles, expected_means.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
